/* hw/rtl/rdnf_pkg.sv */
`default_nettype none
package rdnf_pkg;

	// longest entry name that can match
	localparam int NAME_BYTES = 8;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;

	typedef enum logic [1:0] {
		REG_TARGET_NAME   = 2'd0,
		REG_TARGET_LENGTH = 2'd1,
		REG_TABLE_SIZE    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_LEN    = 3'd0,
		PH_SKIP   = 3'd1,
		PH_PAR_LO = 3'd2,
		PH_PAR_HI = 3'd3,
		PH_NAME   = 3'd4,
		PH_PAD    = 3'd5
	} phase_t;

	typedef struct packed {
		logic [63:0] target_name;
		logic [3:0]  target_length;
		logic [15:0] table_size;
	} cfg_t;

	// number of header bytes skipped between the length byte and the parent number
	localparam logic [7:0] SKIP_BYTES = 8'd5;
	// fixed part of an entry: length, skipped bytes, parent number
	localparam logic [16:0] ENTRY_FIXED = 17'd8;

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h61:8'h7A]}) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/rdnf_regs.sv */
`default_nettype none
module rdnf_regs import rdnf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_name   <= '0;
			cfg_q.target_length <= 4'd1;
			cfg_q.table_size    <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_TARGET_NAME:   cfg_q.target_name   <= pwdata;
				REG_TARGET_LENGTH: cfg_q.target_length <= pwdata[3:0];
				REG_TABLE_SIZE:    cfg_q.table_size    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TARGET_NAME:   prdata = cfg_q.target_name;
			REG_TARGET_LENGTH: prdata = {60'd0, cfg_q.target_length};
			REG_TABLE_SIZE:    prdata = {48'd0, cfg_q.table_size};
			default:           prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/rdnf_parser.sv */
`default_nettype none
module rdnf_parser import rdnf_pkg::*; #(
	parameter int NAME_BYTES = rdnf_pkg::NAME_BYTES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       first_byte,
	input  wire cfg_t       cfg,
	output logic            found,
	output logic            scan_done
);

	phase_t      phase_q, phase_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  len_q, len_d;
	logic        lo_one_q, lo_one_d;
	logic        root_q, root_d;
	logic        match_q, match_d;
	logic [16:0] pos_q, pos_d;
	logic        seen_q, seen_d;
	logic        fin_q, fin_d;

	logic        complete, root_c, match_c, end_req, hit;
	logic [7:0]  cnt_inc, tgt_byte;
	logic [16:0] pos_sum;

	assign found     = seen_q;
	assign scan_done = fin_q;

	assign cnt_inc  = cnt_q + 8'd1;
	assign tgt_byte = cfg.target_name[{cnt_q[2:0], 3'b000} +: 8];
	assign pos_sum  = pos_q + ENTRY_FIXED + {9'd0, len_q} + {16'd0, len_q[0]};

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		lo_one_d = lo_one_q;
		root_d   = root_q;
		match_d  = match_q;
		pos_d    = pos_q;
		seen_d   = seen_q;
		fin_d    = fin_q;
		complete = 1'b0;
		root_c   = root_q;
		match_c  = match_q;
		end_req  = 1'b0;
		hit      = 1'b0;

		if (step && first_byte) begin
			pos_d    = '0;
			seen_d   = 1'b0;
			cnt_d    = '0;
			root_d   = 1'b0;
			lo_one_d = 1'b0;
			match_d  = 1'b1;
			if (cfg.table_size == 16'd0) begin
				fin_d   = 1'b1;
				phase_d = PH_LEN;
				len_d   = '0;
			end else begin
				fin_d   = 1'b0;
				phase_d = PH_SKIP;
				len_d   = data_byte;
			end
		end else if (step && !fin_q) begin
			case (phase_q)
				PH_LEN: begin
					len_d    = data_byte;
					cnt_d    = '0;
					match_d  = 1'b1;
					root_d   = 1'b0;
					lo_one_d = 1'b0;
					phase_d  = PH_SKIP;
				end
				PH_SKIP: begin
					if (cnt_inc >= SKIP_BYTES) begin
						cnt_d   = '0;
						phase_d = PH_PAR_LO;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				PH_PAR_LO: begin
					lo_one_d = (data_byte == 8'd1);
					phase_d  = PH_PAR_HI;
				end
				PH_PAR_HI: begin
					root_c   = lo_one_q && (data_byte == 8'd0);
					root_d   = root_c;
					cnt_d    = '0;
					complete = (len_q == 8'd0);
					if (len_q != 8'd0) begin
						phase_d = PH_NAME;
					end
				end
				PH_NAME: begin
					if (cnt_q < 8'(NAME_BYTES) && cnt_q < 8'd8 &&
					    cnt_q < {4'd0, cfg.target_length}) begin
						match_c = match_q &&
						          (fold_upper(data_byte) == fold_upper(tgt_byte));
					end else begin
						match_c = 1'b0;
					end
					match_d  = match_c;
					cnt_d    = cnt_inc;
					complete = (cnt_inc >= len_q);
				end
				PH_PAD: begin
					end_req = 1'b1;
				end
				default: begin
					phase_d  = PH_LEN;
					cnt_d    = '0;
					len_d    = '0;
					root_d   = 1'b0;
					lo_one_d = 1'b0;
					match_d  = 1'b1;
				end
			endcase

			if (complete) begin
				hit = root_c && match_c && (len_q <= 8'(NAME_BYTES)) &&
				      (len_q == {4'd0, cfg.target_length});
				if (hit) begin
					seen_d = 1'b1;
					fin_d  = 1'b1;
				end else if (len_q[0]) begin
					phase_d = PH_PAD;
				end else begin
					end_req = 1'b1;
				end
			end

			if (end_req) begin
				pos_d    = pos_sum;
				phase_d  = PH_LEN;
				cnt_d    = '0;
				len_d    = '0;
				root_d   = 1'b0;
				lo_one_d = 1'b0;
				match_d  = 1'b1;
				if (pos_sum >= {1'b0, cfg.table_size}) begin
					fin_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN;
			cnt_q    <= '0;
			len_q    <= '0;
			lo_one_q <= 1'b0;
			root_q   <= 1'b0;
			match_q  <= 1'b1;
			pos_q    <= '0;
			seen_q   <= 1'b0;
			fin_q    <= 1'b1;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			lo_one_q <= lo_one_d;
			root_q   <= root_d;
			match_q  <= match_d;
			pos_q    <= pos_d;
			seen_q   <= seen_d;
			fin_q    <= fin_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/root_directory_name_finder_core.sv */
`default_nettype none
// Path table scanner: takes one path table byte per beat and returns one
// result beat per input beat, carrying found and scan_done as they stand
// after that byte. One byte is accepted every cycle while in_ready is high;
// a result is on the outputs once its byte has passed the input register and
// then the parser state registers, which double as the result register.
// The parser update per byte is combinational into them, which sets the
// one-byte-per-cycle rate. A stalled result holds the input register and
// backpressures in_ready. NAME_BYTES sets the longest entry name that can
// match. Configure target_name, target_length and table_size over APB while
// idle; after reset scan_done reads 1 until a beat with first_byte set arrives.
module root_directory_name_finder_core import rdnf_pkg::*; #(
	parameter int NAME_BYTES = rdnf_pkg::NAME_BYTES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  first_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       found,
	output logic                       scan_done,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t       cfg;
	logic       v_s1, v_s2;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       adv;

	// advance when the result slot is empty or being drained
	assign adv       = v_s1 && (!v_s2 || out_ready);
	assign in_ready  = !v_s1 || adv;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	rdnf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rdnf_parser #(
		.NAME_BYTES (NAME_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.data_byte  (byte_s1),
		.first_byte (first_s1),
		.cfg        (cfg),
		.found      (found),
		.scan_done  (scan_done)
	);

endmodule
`default_nettype wire

/* hw/rtl/rdnf_checker.sv */
`default_nettype none
module rdnf_checker import rdnf_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic                  found,
	input wire logic                  scan_done,
	input wire logic                  psel,
	input wire logic                  penable,
	input wire logic                  pwrite,
	input wire logic [CFG_ADDR_W-1:0] paddr,
	input wire logic [CFG_DATA_W-1:0] pwdata,
	input wire logic [CFG_DATA_W-1:0] prdata
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(scan_done))
		else $error("result beat changed while stalled");

	// a match always ends the scan
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> scan_done)
		else $error("found without scan_done");

	// an empty result slot never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

	// table size readback follows the last write
	a_size_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[4:3] == REG_TABLE_SIZE) ##1
		psel && !pwrite && (paddr[4:3] == REG_TABLE_SIZE)
		|-> prdata[15:0] == $past(pwdata[15:0]))
		else $error("table_size readback mismatch");

endmodule

bind root_directory_name_finder_core rdnf_checker u_chk (.*);
`default_nettype wire
